FILE: src/csup_pkg.sv
`timescale 1ns / 1ps
// Package for the chunked sample upload engine.
// Holds sizes, command and error codes, state and response types; depends on nothing.
package csup_pkg;

   localparam int SAMPLE_LEN_DEF   = 2500;
   localparam int MAX_CHUNK_DEF    = 112;
   localparam int PACKET_BYTES_DEF = 160;
   localparam int LEN_W            = 12;
   localparam int HDR_BYTES        = 12;

   localparam logic [15:0] RESP_MAGIC = 16'h3354;

   localparam logic [7:0] OP_PING   = 8'h01;
   localparam logic [7:0] OP_START  = 8'h10;
   localparam logic [7:0] OP_CHUNK  = 8'h11;
   localparam logic [7:0] OP_COMMIT = 8'h12;
   localparam logic [7:0] OP_RESET  = 8'h7F;

   localparam logic [15:0] ERR_START_LEN   = 16'd1;
   localparam logic [15:0] ERR_SAMPLE_LEN  = 16'd2;
   localparam logic [15:0] ERR_NO_SESSION  = 16'd3;
   localparam logic [15:0] ERR_CHUNK_SHORT = 16'd4;
   localparam logic [15:0] ERR_CHUNK_BIG   = 16'd5;
   localparam logic [15:0] ERR_CHUNK_LEN   = 16'd6;
   localparam logic [15:0] ERR_CHUNK_RANGE = 16'd7;
   localparam logic [15:0] ERR_CHUNK_SUM   = 16'd8;
   localparam logic [15:0] ERR_COMMIT_OPEN = 16'd9;
   localparam logic [15:0] ERR_COMMIT_LEN  = 16'd10;
   localparam logic [15:0] ERR_UNKNOWN     = 16'd11;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HDR,
      ST_EXEC,
      ST_CSUM,
      ST_CCHK,
      ST_COPY,
      ST_TSUM,
      ST_TCHK,
      ST_SUM,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic             status;
      logic [7:0]       ack_cmd;
      logic [15:0]      chunk_offset;
      logic [LEN_W-1:0] received_length;
      logic [15:0]      chunk_total;
      logic [15:0]      extra_word;
      logic [15:0]      record_number;
      logic [31:0]      sample_number;
      logic [7:0]       label_echo;
      logic             start_inference;
   } rsp_fields_type;

endpackage

FILE: src/csup_req_if.sv
`timescale 1ns / 1ps
// Byte channel carrying received packet bytes with an end-of-packet mark.
// Depends on nothing.
interface csup_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       packet_end;
   modport source (output valid, output data_byte, output packet_end, input ready);
   modport sink (input valid, input data_byte, input packet_end, output ready);
endinterface

FILE: src/csup_rsp_if.sv
`timescale 1ns / 1ps
// Response record channel, one beat per closed packet.
// Depends on csup_pkg for the record length width.
interface csup_rsp_if import csup_pkg::*;;
   logic             valid;
   logic             ready;
   logic             status;
   logic [7:0]       ack_cmd;
   logic [15:0]      chunk_offset;
   logic [LEN_W-1:0] received_length;
   logic [15:0]      chunk_total;
   logic [15:0]      extra_word;
   logic [15:0]      record_number;
   logic [31:0]      sample_number;
   logic [7:0]       label_echo;
   logic [15:0]      response_sum;
   logic             start_inference;
   modport source (output valid, output status, output ack_cmd, output chunk_offset,
                   output received_length, output chunk_total, output extra_word,
                   output record_number, output sample_number, output label_echo,
                   output response_sum, output start_inference, input ready);
   modport sink (input valid, input status, input ack_cmd, input chunk_offset,
                 input received_length, input chunk_total, input extra_word,
                 input record_number, input sample_number, input label_echo,
                 input response_sum, input start_inference, output ready);
endinterface

FILE: src/csup_rsp_sum.sv
`timescale 1ns / 1ps
// Byte-sum checksum of the 19 little-endian bytes of the packed response record.
// Depends on csup_pkg for the response field type.
module csup_rsp_sum import csup_pkg::*; (
   input  rsp_fields_type fields,
   output logic [15:0]    sum
);

   logic [11:0] total;

   assign total = 12'(RESP_MAGIC[7:0]) + 12'(RESP_MAGIC[15:8])
                + 12'(fields.status) + 12'(fields.ack_cmd)
                + 12'(fields.chunk_offset[7:0]) + 12'(fields.chunk_offset[15:8])
                + 12'(fields.received_length[7:0])
                + 12'(fields.received_length[LEN_W-1:8])
                + 12'(fields.chunk_total[7:0]) + 12'(fields.chunk_total[15:8])
                + 12'(fields.extra_word[7:0]) + 12'(fields.extra_word[15:8])
                + 12'(fields.record_number[7:0]) + 12'(fields.record_number[15:8])
                + 12'(fields.sample_number[7:0]) + 12'(fields.sample_number[15:8])
                + 12'(fields.sample_number[23:16]) + 12'(fields.sample_number[31:24])
                + 12'(fields.label_echo);

   assign sum = 16'(total);

endmodule

FILE: src/chunked_sample_upload_protocol.sv
`timescale 1ns / 1ps
// Top level of the chunked sample upload engine: packet buffer, sample store and sequencer.
// Depends on csup_pkg, csup_req_if, csup_rsp_if and csup_rsp_sum.
//
//   Channel   Direction  Beat
//   req_bus   in         one packet byte, packet_end on the last
//   rsp_bus   out        one response record per closed packet
//
// A byte that does not close a packet leaves the sequencer idle and ready for the next byte.
// A closed packet has its header read (ST_HDR) and its command run (ST_EXEC): a chunk
// is summed (ST_CSUM, ST_CCHK) and copied (ST_COPY), a commit sums the sample store
// (ST_TSUM, ST_TCHK) and a good start or a reset clears it (ST_CLEAR) before the response.
// After reset the sample store is cleared before the first byte is taken.
// No byte is taken while a packet is processed or its response waits on rsp_bus.ready.
module chunked_sample_upload_protocol import csup_pkg::*; #(
   parameter int SAMPLE_LEN   = SAMPLE_LEN_DEF,
   parameter int MAX_CHUNK    = MAX_CHUNK_DEF,
   parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
   input logic        clock,
   input logic        reset,
   csup_req_if.sink   req_bus,
   csup_rsp_if.source rsp_bus
);

   localparam int PAW = $clog2(PACKET_BYTES);
   localparam int PLW = $clog2(PACKET_BYTES + 1);
   localparam int SAW = (SAMPLE_LEN > 1) ? $clog2(SAMPLE_LEN) : 1;
   localparam int CW  = ($clog2(SAMPLE_LEN + 2) > 9) ? $clog2(SAMPLE_LEN + 2) : 9;

   state_type state_ff, state_in;

   logic [7:0]     pkt_mem [PACKET_BYTES];
   logic [7:0]     smp_mem [SAMPLE_LEN];
   logic           pkt_we;
   logic [PAW-1:0] pkt_waddr, pkt_raddr;
   logic [7:0]     pkt_rd_ff;
   logic           smp_we;
   logic [SAW-1:0] smp_waddr, smp_raddr;
   logic [7:0]     smp_wdata, smp_rd_ff;

   logic [PLW-1:0]   plen_ff, plen_in, len_ff, len_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [7:0]       hdr_ff [HDR_BYTES];
   logic             hdr_we;
   logic [3:0]       hdr_idx;
   logic             open_ff, open_in;
   logic [LEN_W-1:0] end_ff, end_in;
   logic [15:0]      chunks_ff, chunks_in;
   logic [15:0]      record_ff, record_in;
   logic [31:0]      sample_ff, sample_in;
   logic [7:0]       label_ff, label_in;
   logic [15:0]      exp_ff, exp_in;
   logic [15:0]      acc_ff, acc_in;
   logic [15:0]      got_ff, got_in;
   logic             clr_rsp_ff, clr_rsp_in;
   rsp_fields_type   fld_ff, fld_in, fld_out;
   logic [15:0]      rsum_ff, rsum_in, rsum_calc;

   logic             req_fire;
   logic [PLW-1:0]   plen_next;
   logic [7:0]       cmd, clen;
   logic [15:0]      off, want, hdr_exp;
   logic [CW-1:0]    cnt_m1, cnt_p4;
   logic [16:0]      endp, smp_off;
   logic [LEN_W-1:0] end_new;
   logic [15:0]      chunks_new;
   logic [15:0]      chunk_err, commit_err;
   logic             start_len_ok, start_ok;

   assign req_fire  = req_bus.valid && req_bus.ready;
   assign plen_next = (plen_ff < PLW'(PACKET_BYTES)) ? plen_ff + 1'b1 : plen_ff;
   assign cmd       = hdr_ff[0];
   assign off       = {hdr_ff[2], hdr_ff[1]};
   assign clen      = hdr_ff[3];
   assign want      = {hdr_ff[9], hdr_ff[8]};
   assign hdr_exp   = {hdr_ff[11], hdr_ff[10]};
   assign cnt_m1    = cnt_ff - 1'b1;
   assign cnt_p4    = cnt_ff + CW'(4);
   assign hdr_idx   = 4'(cnt_m1);
   assign endp      = 17'(off) + 17'(clen);
   assign smp_off   = 17'(off) + 17'(cnt_m1);
   assign end_new   = (endp > 17'(end_ff)) ? LEN_W'(endp) : end_ff;
   assign chunks_new = chunks_ff + 16'd1;

   assign start_len_ok = (9'(len_ff) == 9'(HDR_BYTES));
   assign start_ok     = start_len_ok && (want == 16'(SAMPLE_LEN));

   always_comb begin
      if (!open_ff) begin
         chunk_err = ERR_NO_SESSION;
      end else if (9'(len_ff) < 9'd6) begin
         chunk_err = ERR_CHUNK_SHORT;
      end else if (clen > 8'(MAX_CHUNK)) begin
         chunk_err = ERR_CHUNK_BIG;
      end else if (9'(len_ff) != 9'(clen) + 9'd6) begin
         chunk_err = ERR_CHUNK_LEN;
      end else if (endp > 17'(SAMPLE_LEN)) begin
         chunk_err = ERR_CHUNK_RANGE;
      end else begin
         chunk_err = 16'd0;
      end
      if (!open_ff) begin
         commit_err = ERR_COMMIT_OPEN;
      end else if (end_ff != LEN_W'(SAMPLE_LEN)) begin
         commit_err = ERR_COMMIT_LEN;
      end else begin
         commit_err = 16'd0;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (cnt_ff == CW'(SAMPLE_LEN - 1)) begin
               state_in = clr_rsp_ff ? ST_SUM : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire && req_bus.packet_end) begin
               state_in = ST_HDR;
            end
         end
         ST_HDR: begin
            if (cnt_ff == CW'(HDR_BYTES)) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (cmd)
               OP_RESET:  state_in = ST_CLEAR;
               OP_START:  state_in = start_ok ? ST_CLEAR : ST_SUM;
               OP_CHUNK:  state_in = (chunk_err == 16'd0) ? ST_CSUM : ST_SUM;
               OP_COMMIT: state_in = (commit_err == 16'd0) ? ST_TSUM : ST_SUM;
               default:   state_in = ST_SUM;
            endcase
         end
         ST_CSUM: begin
            if (cnt_ff == CW'(clen) + CW'(2)) begin
               state_in = ST_CCHK;
            end
         end
         ST_CCHK: begin
            state_in = (got_ff == acc_ff) ? ST_COPY : ST_SUM;
         end
         ST_COPY: begin
            if (cnt_ff == CW'(clen)) begin
               state_in = ST_SUM;
            end
         end
         ST_TSUM: begin
            if (cnt_ff == CW'(SAMPLE_LEN)) begin
               state_in = ST_TCHK;
            end
         end
         ST_TCHK: state_in = ST_SUM;
         ST_SUM:  state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_bus.ready = (state_ff == ST_IDLE);
      pkt_we     = 1'b0;
      pkt_waddr  = plen_ff[PAW-1:0];
      pkt_raddr  = cnt_p4[PAW-1:0];
      smp_we     = 1'b0;
      smp_waddr  = cnt_ff[SAW-1:0];
      smp_wdata  = 8'd0;
      smp_raddr  = cnt_ff[SAW-1:0];
      hdr_we     = 1'b0;
      plen_in    = plen_ff;
      len_in     = len_ff;
      cnt_in     = cnt_ff + 1'b1;
      open_in    = open_ff;
      end_in     = end_ff;
      chunks_in  = chunks_ff;
      record_in  = record_ff;
      sample_in  = sample_ff;
      label_in   = label_ff;
      exp_in     = exp_ff;
      acc_in     = acc_ff;
      got_in     = got_ff;
      clr_rsp_in = clr_rsp_ff;
      fld_in     = fld_ff;
      rsum_in    = rsum_ff;
      case (state_ff)
         ST_CLEAR: begin
            smp_we = 1'b1;
         end
         ST_IDLE: begin
            cnt_in = '0;
            if (req_fire) begin
               pkt_we  = (plen_ff < PLW'(PACKET_BYTES));
               plen_in = plen_next;
               if (req_bus.packet_end) begin
                  len_in  = plen_next;
                  plen_in = '0;
               end
            end
         end
         ST_HDR: begin
            pkt_raddr = cnt_ff[PAW-1:0];
            hdr_we    = (cnt_ff != '0);
         end
         ST_EXEC: begin
            cnt_in = '0;
            acc_in = 16'd0;
            fld_in = '{status: 1'b1, ack_cmd: cmd, chunk_offset: 16'd0,
                       received_length: end_ff, chunk_total: chunks_ff,
                       extra_word: ERR_UNKNOWN, record_number: 16'd0,
                       sample_number: 32'd0, label_echo: 8'd0, start_inference: 1'b0};
            case (cmd)
               OP_PING: begin
                  fld_in.status     = 1'b0;
                  fld_in.extra_word = 16'd0;
               end
               OP_RESET: begin
                  open_in    = 1'b0;
                  end_in     = '0;
                  chunks_in  = 16'd0;
                  record_in  = 16'd0;
                  sample_in  = 32'd0;
                  label_in   = 8'd0;
                  exp_in     = 16'd0;
                  clr_rsp_in = 1'b1;
                  fld_in.status          = 1'b0;
                  fld_in.received_length = '0;
                  fld_in.chunk_total     = 16'd0;
                  fld_in.extra_word      = 16'd0;
               end
               OP_START: begin
                  fld_in.received_length = '0;
                  fld_in.chunk_total     = 16'd0;
                  if (!start_len_ok) begin
                     fld_in.extra_word = ERR_START_LEN;
                  end else begin
                     record_in = {hdr_ff[2], hdr_ff[1]};
                     sample_in = {hdr_ff[6], hdr_ff[5], hdr_ff[4], hdr_ff[3]};
                     label_in  = hdr_ff[7];
                     exp_in    = hdr_exp;
                     if (!start_ok) begin
                        fld_in.extra_word = ERR_SAMPLE_LEN;
                     end else begin
                        open_in    = 1'b1;
                        end_in     = '0;
                        chunks_in  = 16'd0;
                        clr_rsp_in = 1'b1;
                        fld_in.status     = 1'b0;
                        fld_in.extra_word = hdr_exp;
                     end
                  end
               end
               OP_CHUNK: begin
                  fld_in.extra_word = chunk_err;
                  if (chunk_err != ERR_NO_SESSION && chunk_err != ERR_CHUNK_SHORT) begin
                     fld_in.chunk_offset = off;
                  end
               end
               OP_COMMIT: begin
                  fld_in.extra_word = commit_err;
               end
               default: begin
               end
            endcase
         end
         ST_CSUM: begin
            if (cnt_ff != '0) begin
               if (cnt_m1 < CW'(clen)) begin
                  acc_in = acc_ff + 16'(pkt_rd_ff);
               end else if (cnt_m1 == CW'(clen)) begin
                  got_in[7:0] = pkt_rd_ff;
               end else begin
                  got_in[15:8] = pkt_rd_ff;
               end
            end
         end
         ST_CCHK: begin
            cnt_in = '0;
            fld_in.extra_word = ERR_CHUNK_SUM;
         end
         ST_COPY: begin
            smp_we    = (cnt_ff != '0);
            smp_waddr = smp_off[SAW-1:0];
            smp_wdata = pkt_rd_ff;
            if (cnt_ff == CW'(clen)) begin
               end_in    = end_new;
               chunks_in = chunks_new;
               fld_in.status          = 1'b0;
               fld_in.received_length = end_new;
               fld_in.chunk_total     = chunks_new;
               fld_in.extra_word      = acc_ff;
            end
         end
         ST_TSUM: begin
            if (cnt_ff != '0) begin
               acc_in = acc_ff + 16'(smp_rd_ff);
            end
         end
         ST_TCHK: begin
            fld_in.status          = (acc_ff != exp_ff);
            fld_in.extra_word      = acc_ff;
            fld_in.start_inference = (acc_ff == exp_ff);
         end
         ST_SUM: begin
            clr_rsp_in = 1'b0;
            rsum_in    = rsum_calc;
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      fld_out = fld_ff;
      fld_out.record_number = record_ff;
      fld_out.sample_number = sample_ff;
      fld_out.label_echo    = label_ff;
   end

   csup_rsp_sum u_rsp_sum (
      .fields (fld_out),
      .sum    (rsum_calc)
   );

   assign rsp_bus.valid           = (state_ff == ST_RESP);
   assign rsp_bus.status          = fld_out.status;
   assign rsp_bus.ack_cmd         = fld_out.ack_cmd;
   assign rsp_bus.chunk_offset    = fld_out.chunk_offset;
   assign rsp_bus.received_length = fld_out.received_length;
   assign rsp_bus.chunk_total     = fld_out.chunk_total;
   assign rsp_bus.extra_word      = fld_out.extra_word;
   assign rsp_bus.record_number   = fld_out.record_number;
   assign rsp_bus.sample_number   = fld_out.sample_number;
   assign rsp_bus.label_echo      = fld_out.label_echo;
   assign rsp_bus.response_sum    = rsum_ff;
   assign rsp_bus.start_inference = fld_out.start_inference;

   always_ff @(posedge clock) begin
      if (pkt_we) begin
         pkt_mem[pkt_waddr] <= req_bus.data_byte;
      end
      pkt_rd_ff <= pkt_mem[pkt_raddr];
   end

   always_ff @(posedge clock) begin
      if (smp_we) begin
         smp_mem[smp_waddr] <= smp_wdata;
      end
      smp_rd_ff <= smp_mem[smp_raddr];
   end

   always_ff @(posedge clock) begin
      if (hdr_we) begin
         hdr_ff[hdr_idx] <= pkt_rd_ff;
      end
      len_ff  <= len_in;
      acc_ff  <= acc_in;
      got_ff  <= got_in;
      fld_ff  <= fld_in;
      rsum_ff <= rsum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         plen_ff    <= '0;
         cnt_ff     <= '0;
         open_ff    <= 1'b0;
         end_ff     <= '0;
         chunks_ff  <= 16'd0;
         record_ff  <= 16'd0;
         sample_ff  <= 32'd0;
         label_ff   <= 8'd0;
         exp_ff     <= 16'd0;
         clr_rsp_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         plen_ff    <= plen_in;
         cnt_ff     <= cnt_in;
         open_ff    <= open_in;
         end_ff     <= end_in;
         chunks_ff  <= chunks_in;
         record_ff  <= record_in;
         sample_ff  <= sample_in;
         label_ff   <= label_in;
         exp_ff     <= exp_in;
         clr_rsp_ff <= clr_rsp_in;
      end
   end

endmodule

FILE: tb/sv/chunked_sample_upload_protocol_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the chunked sample upload engine: packets of bytes go in,
// response records are predicted in SystemVerilog and compared whole, checksum included.
// Depends on csup_pkg, csup_req_if, csup_rsp_if and the block's RTL.
module chunked_sample_upload_protocol_tb;
   import csup_pkg::*;

   localparam int WATCHDOG_LIMIT = 60000;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       packet_end;
   } byte_beat_type;

   typedef struct packed {
      logic [15:0] response_sum;
      rsp_fields_type f;
   } record_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   csup_req_if req_bus ();
   csup_rsp_if rsp_bus ();

   chunked_sample_upload_protocol dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   byte_beat_type pending_bytes[$];
   record_type    awaited_records[$];
   logic [7:0]    pkt_buf[PACKET_BYTES_DEF];
   int            pkt_len;
   logic [7:0]    sample_mem[SAMPLE_LEN_DEF];
   logic          sess_open;
   int            end_pos;
   logic [15:0]   chunk_cnt;
   logic [15:0]   rec_id;
   logic [31:0]   samp_id;
   logic [7:0]    label_val;
   logic [15:0]   want_sum;
   int            mismatches;
   int            watchdog;
   int            gap_left;
   int            stall_left;
   logic          hold_sender;
   logic          req_taken;
   logic [7:0]    shadow[SAMPLE_LEN_DEF];
   logic [15:0]   shadow_sum;

   function automatic int bpair(logic [15:0] v);
      return int'(v[7:0]) + int'(v[15:8]);
   endfunction

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic post_record(logic st, logic [7:0] ack, logic [15:0] off, int rlen,
                              logic [15:0] cnt, logic [15:0] extra, logic go);
      record_type r;
      int s;
      r.f.status = st;
      r.f.ack_cmd = ack;
      r.f.chunk_offset = off;
      r.f.received_length = rlen[LEN_W-1:0];
      r.f.chunk_total = cnt;
      r.f.extra_word = extra;
      r.f.record_number = rec_id;
      r.f.sample_number = samp_id;
      r.f.label_echo = label_val;
      r.f.start_inference = go;
      s = bpair(RESP_MAGIC) + st + ack + bpair(off) + bpair(16'(rlen[LEN_W-1:0]))
          + bpair(cnt) + bpair(extra) + bpair(rec_id) + bpair(samp_id[15:0])
          + bpair(samp_id[31:16]) + label_val;
      r.response_sum = s[15:0];
      awaited_records.push_back(r);
   endtask

   function automatic logic [15:0] le16(int i);
      return {pkt_buf[i+1], pkt_buf[i]};
   endfunction

   task automatic clear_upload_state();
      foreach (sample_mem[i]) sample_mem[i] = 8'h00;
      sess_open = 1'b0;
      end_pos = 0;
      chunk_cnt = 16'd0;
      rec_id = 16'd0;
      samp_id = 32'd0;
      label_val = 8'd0;
      want_sum = 16'd0;
   endtask

   task automatic predict_byte(logic [7:0] b, logic last);
      int len, off, clen, s;
      logic [7:0] cmd;
      if (pkt_len < PACKET_BYTES_DEF) begin
         pkt_buf[pkt_len] = b;
         pkt_len++;
      end
      if (!last) return;
      len = pkt_len;
      pkt_len = 0;
      cmd = pkt_buf[0];
      case (cmd)
         OP_PING: begin
            post_record(1'b0, OP_PING, 16'd0, end_pos, chunk_cnt, 16'd0, 1'b0);
         end
         OP_RESET: begin
            clear_upload_state();
            post_record(1'b0, OP_RESET, 16'd0, 0, 16'd0, 16'd0, 1'b0);
         end
         OP_START: begin
            if (len != HDR_BYTES) begin
               post_record(1'b1, OP_START, 16'd0, 0, 16'd0, ERR_START_LEN, 1'b0);
            end else begin
               rec_id = le16(1);
               samp_id = {le16(5), le16(3)};
               label_val = pkt_buf[7];
               want_sum = le16(10);
               if (le16(8) != 16'(SAMPLE_LEN_DEF)) begin
                  post_record(1'b1, OP_START, 16'd0, 0, 16'd0, ERR_SAMPLE_LEN, 1'b0);
               end else begin
                  end_pos = 0;
                  chunk_cnt = 16'd0;
                  sess_open = 1'b1;
                  foreach (sample_mem[i]) sample_mem[i] = 8'h00;
                  post_record(1'b0, OP_START, 16'd0, 0, 16'd0, want_sum, 1'b0);
               end
            end
         end
         OP_CHUNK: begin
            if (!sess_open) begin
               post_record(1'b1, OP_CHUNK, 16'd0, end_pos, chunk_cnt, ERR_NO_SESSION, 1'b0);
            end else if (len < 6) begin
               post_record(1'b1, OP_CHUNK, 16'd0, end_pos, chunk_cnt, ERR_CHUNK_SHORT, 1'b0);
            end else begin
               off = le16(1);
               clen = pkt_buf[3];
               if (clen > MAX_CHUNK_DEF) begin
                  post_record(1'b1, OP_CHUNK, 16'(off), end_pos, chunk_cnt, ERR_CHUNK_BIG, 1'b0);
               end else if (len != 6 + clen) begin
                  post_record(1'b1, OP_CHUNK, 16'(off), end_pos, chunk_cnt, ERR_CHUNK_LEN, 1'b0);
               end else if (off + clen > SAMPLE_LEN_DEF) begin
                  post_record(1'b1, OP_CHUNK, 16'(off), end_pos, chunk_cnt, ERR_CHUNK_RANGE,
                              1'b0);
               end else begin
                  s = 0;
                  for (int i = 0; i < clen; i++) s += pkt_buf[4+i];
                  if (le16(4 + clen) != s[15:0]) begin
                     post_record(1'b1, OP_CHUNK, 16'(off), end_pos, chunk_cnt, ERR_CHUNK_SUM,
                                 1'b0);
                  end else begin
                     for (int i = 0; i < clen; i++) sample_mem[off+i] = pkt_buf[4+i];
                     if (off + clen > end_pos) end_pos = off + clen;
                     chunk_cnt = chunk_cnt + 16'd1;
                     post_record(1'b0, OP_CHUNK, 16'(off), end_pos, chunk_cnt, s[15:0], 1'b0);
                  end
               end
            end
         end
         OP_COMMIT: begin
            if (!sess_open) begin
               post_record(1'b1, OP_COMMIT, 16'd0, end_pos, chunk_cnt, ERR_COMMIT_OPEN, 1'b0);
            end else if (end_pos != SAMPLE_LEN_DEF) begin
               post_record(1'b1, OP_COMMIT, 16'd0, end_pos, chunk_cnt, ERR_COMMIT_LEN, 1'b0);
            end else begin
               s = 0;
               foreach (sample_mem[i]) s += sample_mem[i];
               post_record(s[15:0] != want_sum, OP_COMMIT, 16'd0, end_pos, chunk_cnt, s[15:0],
                           s[15:0] == want_sum);
            end
         end
         default: begin
            post_record(1'b1, cmd, 16'd0, end_pos, chunk_cnt, ERR_UNKNOWN, 1'b0);
         end
      endcase
   endtask

   task automatic queue_packet(logic [7:0] bytes[$]);
      byte_beat_type b;
      foreach (bytes[i]) begin
         b.data_byte = bytes[i];
         b.packet_end = (i == bytes.size() - 1);
         pending_bytes.push_back(b);
      end
   endtask

   task automatic queue_start(logic [15:0] rec, logic [31:0] smp, logic [7:0] lab,
                              logic [15:0] slen, logic [15:0] sum);
      queue_packet('{OP_START, rec[7:0], rec[15:8], smp[7:0], smp[15:8], smp[23:16],
                     smp[31:24], lab, slen[7:0], slen[15:8], sum[7:0], sum[15:8]});
   endtask

   task automatic queue_chunk(int off, int clen, logic corrupt, logic update_shadow);
      logic [7:0] bytes[$];
      logic [7:0] v;
      int s;
      s = 0;
      bytes = '{OP_CHUNK, off[7:0], off[15:8], clen[7:0]};
      for (int i = 0; i < clen; i++) begin
         v = 8'($urandom);
         bytes.push_back(v);
         s += v;
         if (update_shadow && off + i < SAMPLE_LEN_DEF) shadow[off+i] = v;
      end
      if (corrupt) s += 1;
      bytes.push_back(s[7:0]);
      bytes.push_back(s[15:8]);
      queue_packet(bytes);
   endtask

   // The chunks are built first so that the start header can carry their total sum.
   task automatic queue_session(logic good_sum);
      byte_beat_type held[$];
      byte_beat_type chunk_beats[$];
      int off, clen, n, s;
      logic [15:0] sum;
      foreach (shadow[i]) shadow[i] = 8'h00;
      held = pending_bytes;
      pending_bytes.delete();
      n = $urandom_range(0, 3);
      for (int k = 0; k < n; k++) begin
         clen = $urandom_range(1, MAX_CHUNK_DEF);
         off = $urandom_range(0, SAMPLE_LEN_DEF - clen);
         queue_chunk(off, clen, 1'b0, 1'b1);
      end
      if ($urandom_range(0, 4) == 0) queue_chunk($urandom_range(0, 100), 8, 1'b1, 1'b0);
      if ($urandom_range(0, 3) != 0) begin
         clen = $urandom_range(1, MAX_CHUNK_DEF);
         queue_chunk(SAMPLE_LEN_DEF - clen, clen, 1'b0, 1'b1);
      end
      chunk_beats = pending_bytes;
      pending_bytes = held;
      s = 0;
      foreach (shadow[i]) s += shadow[i];
      shadow_sum = s[15:0];
      sum = good_sum ? shadow_sum : shadow_sum + 16'd1;
      queue_start(16'($urandom), $urandom, 8'($urandom), 16'(SAMPLE_LEN_DEF), sum);
      foreach (chunk_beats[i]) pending_bytes.push_back(chunk_beats[i]);
      queue_packet('{OP_COMMIT});
   endtask

   task automatic queue_noise();
      logic [7:0] bytes[$];
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 175) : $urandom_range(1, 14);
      for (int i = 0; i < n; i++) bytes.push_back(8'($urandom));
      if ($urandom_range(0, 1)) bytes[0] = ($urandom_range(0, 1)) ? OP_CHUNK : OP_START;
      queue_packet(bytes);
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.data_byte = 8'h00;
      req_bus.packet_end = 1'b0;
      rsp_bus.ready = 1'b0;
      pkt_len = 0;
      mismatches = 0;
      hold_sender = 1'b0;
      req_taken = 1'b0;
      clear_upload_state();

      // Directed packets: error paths before and after a session opens, then reset and a good session.
      queue_packet('{OP_PING});
      queue_packet('{OP_CHUNK, 8'h00, 8'h00, 8'h01, 8'h05, 8'h05, 8'h00});
      queue_packet('{OP_COMMIT});
      queue_packet('{8'hFF});
      queue_packet('{8'h00, 8'hAA});
      queue_packet('{OP_START, 8'h01});
      queue_start(16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 16'd100, 16'hFFFF);
      queue_start(16'h1234, 32'h89AB_CDEF, 8'h5A, 16'(SAMPLE_LEN_DEF), 16'h0000);
      queue_packet('{OP_CHUNK, 8'h00, 8'h00});
      queue_packet('{OP_CHUNK, 8'h00, 8'h00, 8'd113, 8'h00, 8'h00});
      queue_packet('{OP_CHUNK, 8'h00, 8'h00, 8'd4, 8'h01, 8'h00});
      queue_chunk(SAMPLE_LEN_DEF - 2, 3, 1'b0, 1'b0);
      queue_chunk(65535, 1, 1'b0, 1'b0);
      queue_chunk(10, 5, 1'b1, 1'b0);
      queue_chunk(0, 0, 1'b0, 1'b0);
      queue_chunk(SAMPLE_LEN_DEF - MAX_CHUNK_DEF, MAX_CHUNK_DEF, 1'b0, 1'b0);
      queue_packet('{OP_COMMIT});
      queue_noise();
      queue_packet('{OP_RESET});
      queue_packet('{OP_PING});
      queue_session(1'b1);

      // Sessions with random content, broken ones and noise in between.
      while (pending_bytes.size() < 1500) begin
         case ($urandom_range(0, 5))
            0, 1: queue_session($urandom_range(0, 3) != 0);
            2: queue_noise();
            3: queue_packet('{OP_COMMIT});
            4: queue_packet('{OP_PING});
            default: queue_chunk($urandom_range(0, SAMPLE_LEN_DEF - 1),
                                 $urandom_range(0, MAX_CHUNK_DEF + 2),
                                 $urandom_range(0, 3) == 0, 1'b0);
         endcase
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // Request beats are predicted at the edge that accepts them.
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset && req_bus.valid && req_bus.ready) begin
         req_taken = 1'b1;
         predict_byte(req_bus.data_byte, req_bus.packet_end);
      end
   end

   // Sender: one byte per beat, held until it is accepted.
   always @(negedge clock) begin
      if (reset) begin
         gap_left <= 0;
      end else if (!req_bus.valid || req_taken) begin
         if (gap_left > 0 || hold_sender || pending_bytes.size() == 0) begin
            req_bus.valid <= 1'b0;
            if (gap_left > 0) gap_left <= gap_left - 1;
         end else begin
            req_bus.valid <= 1'b1;
            req_bus.data_byte <= pending_bytes[0].data_byte;
            req_bus.packet_end <= pending_bytes[0].packet_end;
            void'(pending_bytes.pop_front());
            gap_left <= gap_length();
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         stall_left <= ($urandom_range(0, 2) == 0) ? gap_length() : 0;
      end
   end

   always @(posedge clock) begin
      record_type got, exp;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.f.status = rsp_bus.status;
         got.f.ack_cmd = rsp_bus.ack_cmd;
         got.f.chunk_offset = rsp_bus.chunk_offset;
         got.f.received_length = rsp_bus.received_length;
         got.f.chunk_total = rsp_bus.chunk_total;
         got.f.extra_word = rsp_bus.extra_word;
         got.f.record_number = rsp_bus.record_number;
         got.f.sample_number = rsp_bus.sample_number;
         got.f.label_echo = rsp_bus.label_echo;
         got.f.start_inference = rsp_bus.start_inference;
         got.response_sum = rsp_bus.response_sum;
         if (awaited_records.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat %p", got);
         end else begin
            exp = awaited_records.pop_front();
            if (got !== exp) begin
               mismatches++;
               if (mismatches <= 10) $display("response mismatch: expected %p, got %p", exp, got);
            end
         end
      end
   end

   initial begin
      @(negedge reset);
      watchdog = 0;
      while (pending_bytes.size() != 0 || req_bus.valid || awaited_records.size() != 0) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            watchdog = 0;
         else
            watchdog++;
         if (watchdog >= WATCHDOG_LIMIT) begin
            $display("** chunked_sample_upload_protocol: FAILED **");
            $finish;
         end
      end
      repeat (50) @(posedge clock);
      if (mismatches == 0 && awaited_records.size() == 0) begin
         $display("** chunked_sample_upload_protocol: PASSED **");
      end else begin
         $display("** chunked_sample_upload_protocol: FAILED **");
      end
      $finish;
   end

   initial begin
      @(negedge reset);
      repeat (3000) @(posedge clock);
      hold_sender = 1'b1;
      while (awaited_records.size() != 0 || req_bus.valid) @(posedge clock);
      hold_sender = 1'b0;
   end

endmodule
